### hw/rtl/lie_pkg.sv
// Shared types and constants for the logical-immediate instruction encoder.
// No dependencies.
package lie_pkg;

	localparam int ImmW     = 64;
	localparam int OpW      = 9;
	localparam int RegW     = 5;
	localparam int WordW    = 32;
	localparam int ShiftW   = 6;   // immr / imms / bit index width
	localparam int LogW     = 3;   // log2 of element size, 1..6
	localparam int CountW   = 7;   // holds 0..64
	localparam int ChunkW   = 8;
	localparam int NumChunk = ImmW / ChunkW;
	localparam int PartW    = 4;   // popcount of one chunk, 0..8

	localparam logic [LogW-1:0] LogE64 = 3'd6;

	typedef struct packed {
		logic [OpW-1:0]  opcode_top;
		logic [RegW-1:0] src_reg;
		logic [RegW-1:0] dst_reg;
		logic [ImmW-1:0] immediate;
	} req_t;

	typedef struct packed {
		logic [WordW-1:0] instruction_word;
		logic             encodable;
	} rsp_t;

	// Result of the repeat-period search on one immediate.
	typedef struct packed {
		logic [LogW-1:0] esize_log;
		logic [ImmW-1:0] emask;
	} period_t;

endpackage

### hw/rtl/lie_period_detect.sv
// Finds the smallest repeating element (2..64 bits) of a 64-bit immediate
// and the matching element mask. Uses lie_pkg.
module lie_period_detect (
	input  logic [lie_pkg::ImmW-1:0] imm,
	output lie_pkg::period_t         period
);
	import lie_pkg::*;

	logic eq32, eq16, eq8, eq4, eq2;

	assign eq32 = imm[31:0]  == imm[63:32];
	assign eq16 = imm[15:0]  == imm[31:16];
	assign eq8  = imm[7:0]   == imm[15:8];
	assign eq4  = imm[3:0]   == imm[7:4];
	assign eq2  = imm[1:0]   == imm[3:2];

	// halving stops at the first mismatch
	always_comb begin
		if (!eq32) begin
			period.esize_log = 3'd6;
			period.emask     = {64{1'b1}};
		end else if (!eq16) begin
			period.esize_log = 3'd5;
			period.emask     = {32'd0, {32{1'b1}}};
		end else if (!eq8) begin
			period.esize_log = 3'd4;
			period.emask     = {48'd0, {16{1'b1}}};
		end else if (!eq4) begin
			period.esize_log = 3'd3;
			period.emask     = {56'd0, {8{1'b1}}};
		end else if (!eq2) begin
			period.esize_log = 3'd2;
			period.emask     = {60'd0, {4{1'b1}}};
		end else begin
			period.esize_log = 3'd1;
			period.emask     = {62'd0, {2{1'b1}}};
		end
	end

endmodule

### hw/rtl/logical_immediate_instruction_encoder.sv
// Logical-immediate instruction encoder: top level, three pipeline stages.
// A request is registered in stage 1, then stage 2, then the stage 3 output register that drives rsp.
// Throughput: one instruction per cycle; a stalled stage holds, earlier stages fill bubbles.
// Reset: arst_n clears the stage valid bits only. Uses lie_pkg, lie_period_detect.
module logical_immediate_instruction_encoder (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  lie_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lie_pkg::rsp_t rsp
);
	import lie_pkg::*;

	// stage 1: period found, immediate kept
	logic                  valid_s1;
	logic [OpW-1:0]        op_s1;
	logic [RegW-1:0]       rn_s1, rd_s1;
	logic [ImmW-1:0]       imm_s1;
	period_t               period_s1;

	// stage 2: run-start bits and chunk popcounts of the element
	logic                  valid_s2;
	logic [OpW-1:0]        op_s2;
	logic [RegW-1:0]       rn_s2, rd_s2;
	logic [LogW-1:0]       esize_log_s2;
	logic [ImmW-1:0]       starts_s2;
	logic [PartW-1:0]      part_s2 [NumChunk];

	// stage 3: output register
	logic                  valid_s3;
	rsp_t                  rsp_s3;

	logic                  en1, en2, en3;
	period_t               period_c;

	assign en3       = !valid_s3 || !rsp_stall;
	assign en2       = !valid_s2 || en3;
	assign en1       = !valid_s1 || en2;
	assign req_stall = !en1;

	lie_period_detect u_period (
		.imm    (req.immediate),
		.period (period_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && req_valid) begin
			op_s1     <= req.opcode_top;
			rn_s1     <= req.src_reg;
			rd_s1     <= req.dst_reg;
			imm_s1    <= req.immediate;
			period_s1 <= period_c;
		end
	end

	// A bit starts a run when it is set and its cyclic lower neighbor is clear.
	// The immediate repeats with the element period, so bit 63 stands for the
	// element's top bit.
	logic [ImmW-1:0]  starts_c;
	logic [ImmW-1:0]  elem_c;
	logic [PartW-1:0] part_c [NumChunk];

	always_comb begin
		starts_c = imm_s1 & ~{imm_s1[ImmW-2:0], imm_s1[ImmW-1]} & period_s1.emask;
		elem_c   = imm_s1 & period_s1.emask;
		for (int c = 0; c < NumChunk; c++) begin
			part_c[c] = '0;
			for (int b = 0; b < ChunkW; b++) begin
				part_c[c] = part_c[c] + PartW'(elem_c[c*ChunkW+b]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			op_s2        <= op_s1;
			rn_s2        <= rn_s1;
			rd_s2        <= rd_s1;
			esize_log_s2 <= period_s1.esize_log;
			starts_s2    <= starts_c;
			part_s2      <= part_c;
		end
	end

	// Exactly one run start in the element means a single rotated run;
	// zero and all-ones have no start at all.
	logic                one_run;
	logic [ShiftW-1:0]   rot;
	logic [CountW-1:0]   len;
	logic [CountW-1:0]   esize;
	logic [ShiftW-1:0]   immr, imms, emsk;
	logic                nbit;
	logic [12:0]         field;

	always_comb begin
		one_run = (starts_s2 != '0) && ((starts_s2 & (starts_s2 - 1'b1)) == '0);
		rot = '0;
		for (int i = 0; i < ImmW; i++) begin
			if (starts_s2[i]) begin
				rot = rot | ShiftW'(i);
			end
		end
		len = '0;
		for (int c = 0; c < NumChunk; c++) begin
			len = len + CountW'(part_s2[c]);
		end
		esize = CountW'(1) << esize_log_s2;
		emsk  = ShiftW'(esize - 1'b1);
		nbit  = esize_log_s2 == LogE64;
		immr  = ShiftW'(esize - CountW'(rot)) & emsk;
		imms  = ({~emsk[ShiftW-2:0], 1'b0}) | ShiftW'(len - 1'b1);
		field = one_run ? {nbit, immr, imms} : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			rsp_s3.instruction_word <= {op_s2, field, rn_s2, rd_s2};
			rsp_s3.encodable        <= one_run;
		end
	end

	assign rsp_valid = valid_s3;
	assign rsp       = rsp_s3;

endmodule
